[rtl/trp_pkg.sv]
// ----------------------------------------------------------------------------
// trp_pkg
// types, byte codes and the are-you-there answer for the telnet rx parser
// ----------------------------------------------------------------------------
package trp_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_IP   = 8'd244;
	localparam logic [7:0] B_AYT  = 8'd246;
	localparam logic [7:0] B_NUL  = 8'd0;
	localparam logic [7:0] B_LF   = 8'd10;
	localparam logic [7:0] B_CR   = 8'd13;
	localparam logic [7:0] B_ETX  = 8'h03;

	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;

	localparam logic TGT_USER = 1'b0;
	localparam logic TGT_PEER = 1'b1;

	// kind of result group held in the output stage
	localparam logic [1:0] K_USER  = 2'd0;
	localparam logic [1:0] K_REPLY = 2'd1;
	localparam logic [1:0] K_AYT   = 2'd2;

	localparam logic [2:0] LAST_USER  = 3'd0;
	localparam logic [2:0] LAST_REPLY = 3'd2;
	localparam logic [2:0] LAST_AYT   = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic       echo;
	} desc_t;

	function automatic logic [7:0] ayt_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h5b;
			3'd1: c = 8'h79;
			3'd2: c = 8'h65;
			3'd3: c = 8'h73;
			3'd4: c = 8'h5d;
			3'd5: c = B_CR;
			default: c = B_LF;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] last_idx(input logic [1:0] kind);
		logic [2:0] l;
		case (kind)
			K_REPLY: l = LAST_REPLY;
			K_AYT:   l = LAST_AYT;
			default: l = LAST_USER;
		endcase
		return l;
	endfunction

endpackage

[rtl/telnet_receive_parser_core.sv]
// ----------------------------------------------------------------------------
// telnet_receive_parser_core
// telnet receive parser: one received byte per item in, user data and
// negotiation replies out
// ----------------------------------------------------------------------------
// Takes one byte per cycle while out_ready is high. A byte gives zero or
// one result except an option request (three reply bytes to the peer) and
// are-you-there (seven bytes to the peer); while such a group drains from
// the single result register the input is held off. Bytes with no result
// are taken whenever the result register is free or about to hand over its
// last byte. out_target is 0 for user data and 1 for bytes sent to the
// peer; out_last marks the last result of an input byte.
module telnet_receive_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_target,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       echo_local
);
	import trp_pkg::*;

	logic  accept;
	logic  has_result;
	logic  can_load;
	desc_t desc;

	assign in_ready = can_load;
	assign accept   = in_valid && in_ready;

	trp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.accept     (accept),
		.has_result (has_result),
		.desc       (desc)
	);

	trp_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && has_result),
		.desc       (desc),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_target (out_target),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.echo_local (echo_local)
	);

endmodule

[rtl/trp_parser.sv]
// ----------------------------------------------------------------------------
// trp_parser
// parse state, pending verb, cr flag and echo flag; decodes one byte into a
// result group for the output stage
// ----------------------------------------------------------------------------
module trp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     rx_byte,
	input  logic           accept,
	output logic           has_result,
	output trp_pkg::desc_t desc
);
	import trp_pkg::*;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_IAC     = 3'd1;
	localparam logic [2:0] ST_OPTION  = 3'd2;
	localparam logic [2:0] ST_SUB     = 3'd3;
	localparam logic [2:0] ST_SUB_IAC = 3'd4;

	localparam logic [1:0] V_DONT = 2'd0;
	localparam logic [1:0] V_DO   = 2'd1;
	localparam logic [1:0] V_WONT = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] verb_q, verb_d;
	logic       cr_q, cr_d;
	logic       echo_q, echo_d;
	logic [7:0] verb_diff;
	logic [7:0] reply;

	assign verb_diff = B_DONT - rx_byte;

	always_comb begin
		state_d    = ST_DATA;
		verb_d     = verb_q;
		cr_d       = cr_q;
		echo_d     = echo_q;
		has_result = 1'b0;
		reply      = B_WONT;
		desc.kind   = K_USER;
		desc.byte_a = rx_byte;
		case (state_q)
			ST_SUB: begin
				state_d = (rx_byte == B_IAC) ? ST_SUB_IAC : ST_SUB;
			end
			ST_SUB_IAC: begin
				state_d = (rx_byte == B_SE) ? ST_DATA : ST_SUB;
			end
			ST_OPTION: begin
				case (verb_q)
					V_DONT: reply = B_WONT;
					V_DO:   reply = (rx_byte == OPT_SGA) ? B_WILL : B_WONT;
					V_WONT: begin
						reply = B_DONT;
						if (rx_byte == OPT_ECHO)
							echo_d = 1'b1;
					end
					default: begin
						if (rx_byte == OPT_ECHO) begin
							echo_d = 1'b0;
							reply  = B_DO;
						end else if (rx_byte == OPT_SGA) begin
							reply = B_DO;
						end else begin
							reply = B_DONT;
						end
					end
				endcase
				has_result = 1'b1;
				desc.kind  = K_REPLY;
			end
			ST_IAC: begin
				if (rx_byte == B_IAC) begin
					has_result = 1'b1;
				end else if (rx_byte inside {B_DO, B_DONT, B_WILL, B_WONT}) begin
					verb_d  = verb_diff[1:0];
					state_d = ST_OPTION;
				end else if (rx_byte == B_SB) begin
					state_d = ST_SUB;
				end else if (rx_byte == B_IP) begin
					has_result  = 1'b1;
					desc.byte_a = B_ETX;
				end else if (rx_byte == B_AYT) begin
					has_result = 1'b1;
					desc.kind  = K_AYT;
				end
			end
			default: begin
				if (rx_byte == B_IAC) begin
					state_d = ST_IAC;
				end else if (cr_q && (rx_byte == B_NUL || rx_byte == B_LF)) begin
					cr_d = 1'b0;
				end else if (rx_byte == B_CR) begin
					cr_d        = 1'b1;
					has_result  = 1'b1;
					desc.byte_a = B_LF;
				end else begin
					cr_d       = 1'b0;
					has_result = 1'b1;
				end
			end
		endcase
		desc.byte_b = reply;
		desc.echo   = echo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			verb_q  <= V_DONT;
			cr_q    <= 1'b0;
			echo_q  <= 1'b1;
		end else if (accept) begin
			state_q <= state_d;
			verb_q  <= verb_d;
			cr_q    <= cr_d;
			echo_q  <= echo_d;
		end
	end

	// codes above sub-iac are never reached from reset
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= ST_SUB_IAC)
		else $error("parser state out of range");

endmodule

[rtl/trp_emitter.sv]
// ----------------------------------------------------------------------------
// trp_emitter
// result register: holds one result group and sends its bytes in order
// ----------------------------------------------------------------------------
module trp_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  trp_pkg::desc_t desc,
	output logic           can_load,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_target,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           echo_local
);
	import trp_pkg::*;

	logic       busy_q;
	desc_t      desc_q;
	logic [2:0] idx_q;
	logic       fire;
	logic       last;

	assign last       = (idx_q == last_idx(desc_q.kind));
	assign fire       = busy_q && out_ready;
	assign can_load   = !busy_q || (out_ready && last);
	assign out_valid  = busy_q;
	assign out_last   = last;
	assign out_target = (desc_q.kind == K_USER) ? TGT_USER : TGT_PEER;
	assign echo_local = desc_q.echo;

	always_comb begin
		case (desc_q.kind)
			K_REPLY: begin
				case (idx_q)
					3'd0:    out_byte = B_IAC;
					3'd1:    out_byte = desc_q.byte_b;
					default: out_byte = desc_q.byte_a;
				endcase
			end
			K_AYT:   out_byte = ayt_char(idx_q);
			default: out_byte = desc_q.byte_a;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (fire) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_q <= desc;
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= last_idx(desc_q.kind)))
		else $error("result index past end of group");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("group loaded over one still in flight");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && idx_q == 3'd0))
		else $error("new group did not start at first byte");

	a_reply_head: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && desc_q.kind == K_REPLY && idx_q == 3'd0) |-> (out_byte == B_IAC))
		else $error("option reply does not open with iac");

endmodule

[sim/trp_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trp_check
// watches both channels of the telnet receive parser, works out the bytes
// each accepted item must produce and compares them in order as they leave
// ----------------------------------------------------------------------------
module trp_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       out_target,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	input  logic       echo_local,
	output int         fail_count,
	output int         pending
);
	import trp_pkg::*;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_IAC,
		PS_OPTION,
		PS_SUB,
		PS_SUB_IAC
	} parse_e;

	typedef struct packed {
		logic       target;
		logic [7:0] value;
		logic       last;
		logic       echo;
	} result_t;

	localparam logic [55:0] AYT_TEXT = {"[yes]", B_CR, B_LF};

	parse_e     ps;
	logic [7:0] verb;
	logic       cr_seen;
	logic       echo_on;
	int         errs;
	result_t    due_bytes[$];

	assign fail_count = errs;

	task automatic parse_byte(input logic [7:0] b);
		result_t    grp[$];
		logic [7:0] reply;
		case (ps)
			PS_SUB: begin
				if (b == B_IAC)
					ps = PS_SUB_IAC;
			end
			PS_SUB_IAC: begin
				ps = (b == B_SE) ? PS_DATA : PS_SUB;
			end
			PS_OPTION: begin
				case (verb)
					B_WILL: begin
						if (b == OPT_ECHO) begin
							echo_on = 1'b0;
							reply = B_DO;
						end else if (b == OPT_SGA) begin
							reply = B_DO;
						end else begin
							reply = B_DONT;
						end
					end
					B_WONT: begin
						if (b == OPT_ECHO)
							echo_on = 1'b1;
						reply = B_DONT;
					end
					B_DO: begin
						reply = (b == OPT_SGA) ? B_WILL : B_WONT;
					end
					default: begin
						reply = B_WONT;
					end
				endcase
				grp.push_back('{TGT_PEER, B_IAC, 1'b0, 1'b0});
				grp.push_back('{TGT_PEER, reply, 1'b0, 1'b0});
				grp.push_back('{TGT_PEER, b, 1'b0, 1'b0});
				ps = PS_DATA;
			end
			PS_IAC: begin
				ps = PS_DATA;
				if (b == B_IAC) begin
					grp.push_back('{TGT_USER, B_IAC, 1'b0, 1'b0});
				end else if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
					verb = b;
					ps = PS_OPTION;
				end else if (b == B_SB) begin
					ps = PS_SUB;
				end else if (b == B_IP) begin
					grp.push_back('{TGT_USER, B_ETX, 1'b0, 1'b0});
				end else if (b == B_AYT) begin
					for (int k = 0; k < 7; k++)
						grp.push_back('{TGT_PEER, AYT_TEXT[55 - 8 * k -: 8], 1'b0, 1'b0});
				end
			end
			default: begin
				ps = PS_DATA;
				if (b == B_IAC) begin
					ps = PS_IAC;
				end else if (cr_seen && (b == B_NUL || b == B_LF)) begin
					cr_seen = 1'b0;
				end else if (b == B_CR) begin
					cr_seen = 1'b1;
					grp.push_back('{TGT_USER, B_LF, 1'b0, 1'b0});
				end else begin
					cr_seen = 1'b0;
					grp.push_back('{TGT_USER, b, 1'b0, 1'b0});
				end
			end
		endcase
		for (int k = 0; k < grp.size(); k++) begin
			grp[k].echo = echo_on;
			grp[k].last = (k == grp.size() - 1);
			due_bytes.push_back(grp[k]);
		end
	endtask

	task automatic check_field(input string what, input logic [7:0] want_v,
	                           input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
			errs++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (due_bytes.size() == 0) begin
			$display("%0t: unexpected result target %0h byte %0h last %0h echo %0h",
			         $time, out_target, out_byte, out_last, echo_local);
			errs++;
		end else begin
			want = due_bytes.pop_front();
			check_field("out_target", {7'd0, want.target}, {7'd0, out_target});
			check_field("out_byte", want.value, out_byte);
			check_field("out_last", {7'd0, want.last}, {7'd0, out_last});
			check_field("echo_local", {7'd0, want.echo}, {7'd0, echo_local});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps = PS_DATA;
			verb = B_DONT;
			cr_seen = 1'b0;
			echo_on = 1'b1;
			errs = 0;
			due_bytes.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			pending <= due_bytes.size();
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// telnet receive parser regression: directed command and line-end cases,
// then phases of random telnet sequences under sender and receiver idling
// ----------------------------------------------------------------------------
module tb;
	import trp_pkg::*;

	localparam int LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       out_target;
	logic [7:0] out_byte;
	logic       out_last;
	logic       echo_local;
	int         fails;
	int         pending;
	int         cycles = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         live_items;

	telnet_receive_parser_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_target (out_target),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.echo_local (echo_local)
	);

	trp_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_target (out_target),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.echo_local (echo_local),
		.fail_count (fails),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_sequence();
		logic [7:0] verbs[4];
		int         pick;
		int         len;
		verbs = '{B_WILL, B_WONT, B_DO, B_DONT};
		pick = $urandom_range(99);
		if (pick < 30) begin
			push_byte(8'($urandom_range(254)));
			live_items += 1;
		end else if (pick < 40) begin
			push_byte(B_CR);
			case ($urandom_range(3))
				0: push_byte(B_NUL);
				1: push_byte(B_LF);
				2: push_byte(B_CR);
				default: push_byte(8'($urandom_range(254)));
			endcase
			live_items += 2;
		end else if (pick < 48) begin
			push_byte(B_IAC);
			push_byte(B_IAC);
			live_items += 2;
		end else if (pick < 56) begin
			push_byte(B_IAC);
			push_byte($urandom_range(1) ? B_IP : 8'($urandom_range(255)));
			live_items += 2;
		end else if (pick < 62) begin
			push_byte(B_IAC);
			push_byte(B_AYT);
			live_items += 2;
		end else if (pick < 82) begin
			push_byte(B_IAC);
			push_byte(verbs[$urandom_range(3)]);
			case ($urandom_range(2))
				0: push_byte(OPT_ECHO);
				1: push_byte(OPT_SGA);
				default: push_byte(8'($urandom_range(255)));
			endcase
			live_items += 3;
		end else if (pick < 90) begin
			push_byte(B_IAC);
			push_byte(B_SB);
			len = $urandom_range(4);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(3) == 0) begin
					push_byte(B_IAC);
					push_byte(8'($urandom_range(239)));
					live_items += 2;
				end else begin
					push_byte(8'($urandom_range(254)));
					live_items += 1;
				end
			end
			push_byte(B_IAC);
			push_byte(B_SE);
			live_items += 4;
		end else begin
			push_byte(8'($urandom_range(255)));
			live_items += 1;
		end
	endtask

	task automatic run_phase(input int send_idle, input int recv_stall, input int n_items);
		idle_pct = send_idle;
		stall_pct = recv_stall;
		live_items = 0;
		while (live_items < n_items)
			send_sequence();
		drain();
	endtask

	initial begin
		logic [7:0] directed[25];
		directed = '{8'h00, B_CR, B_NUL, B_CR, B_IAC, B_IP, B_LF, B_IAC, B_IAC,
		             B_IAC, B_AYT, B_IAC, B_WILL, OPT_ECHO, B_IAC, B_DONT, B_IAC,
		             B_IAC, B_SB, B_IAC, B_IAC, B_IAC, B_SE, B_IAC, 8'hf1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k])
			push_byte(directed[k]);
		drain();
		run_phase(0, 0, 100);
		run_phase(56, 0, 100);
		run_phase(0, 56, 100);
		run_phase(27, 27, 100);
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
rtl/trp_pkg.sv
rtl/trp_parser.sv
rtl/trp_emitter.sv
rtl/telnet_receive_parser_core.sv
sim/trp_check.sv
sim/tb.sv
